[rtl/bitmap_page_allocator_assert.svh]
// Assertion macros used by the allocator (bitmap_page_allocator.sv).
// Each expects clk and rst in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bpa_pkg.sv]
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int KIND_W  = 2;
  localparam int PAGE_W  = 12;
  localparam int COUNT_W = 13;

  typedef logic [KIND_W-1:0]  kind_code_t;
  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam kind_code_t KIND_ALLOC   = 2'd0;
  localparam kind_code_t KIND_FREE    = 2'd1;
  localparam kind_code_t KIND_RESERVE = 2'd2;

  localparam count_t PAGE_COUNT_RESET = 13'd4096;

endpackage

[rtl/bpa_if.sv]
`timescale 1ns / 1ps
interface bpa_req_if import bpa_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_code_t kind;
  page_t      page_index;

  modport source (output valid, output kind, output page_index, input ready);
  modport sink (input valid, input kind, input page_index, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic  valid;
  logic  ready;
  page_t result_page;
  logic  ok;

  modport source (output valid, output result_page, output ok, input ready);
  modport sink (input valid, input result_page, input ok, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t page_count;

  modport source (output valid, output page_count, input ready);
  modport sink (input valid, input page_count, output ready);
endinterface

[rtl/bpa_ram.sv]
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bpa_div.sv]
`timescale 1ns / 1ps
module bpa_div #(
  parameter int DIVISOR = 64,
  parameter int DVD_W   = 12,
  parameter int REM_W   = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [REM_W-1:0] remainder
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        quotient  <= DVD_W'(dividend / DIVISOR);
        remainder <= REM_W'(dividend % DIVISOR);
      end
    end
  end

endmodule

[rtl/bitmap_page_allocator.sv]
`timescale 1ns / 1ps
// Allocate: one map word checked per cycle from word 0, up to MAX_PAGES / MAP_WORD_BITS words
//   scanned. Free / reserve in range: index split, word read, word write. One request at a
//   time; a result not taken holds the block. Reset: synchronous, active high; the map is
//   then filled with ones, one word per cycle.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES     = 4096,
  parameter int MAP_WORD_BITS = 64
) (
  input logic      clk,
  input logic      rst,
  bpa_cfg_if.sink  cfg,
  bpa_req_if.sink  req,
  bpa_rsp_if.source rsp
);

  `include "bitmap_page_allocator_assert.svh"

  localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WA        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(MAX_PAGES + MAP_WORD_BITS + 1);
  localparam int LW        = BW > COUNT_W ? BW : COUNT_W;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam logic [WA-1:0] LAST_WORD = WA'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DIV, ST_MOD, ST_DONE
  } state_t;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  state_t           state;
  count_t           page_count;
  logic [WA-1:0]    word;
  logic [BW-1:0]    base;
  kind_code_t       kind_q;
  page_t            idx_q;
  page_t            res_page;
  logic             res_ok;

  logic [BW-1:0]    limit;
  logic [LW-1:0]    count_ext;
  logic             accept;
  logic             idx_in_range;
  logic [BW-1:0]    span;
  map_word_t        valid_mask;
  map_word_t        free_bits;
  logic             found_any;
  logic [BIT_W-1:0] found_bit;
  logic             scan_end;

  logic             ram_we;
  logic [WA-1:0]    ram_waddr;
  map_word_t        ram_wdata;
  logic             ram_re;
  logic [WA-1:0]    ram_raddr;
  map_word_t        ram_rdata;

  logic             div_start;
  logic             div_done;
  page_t            div_quot;
  logic [BIT_W-1:0] div_rem;

  bpa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_div #(
    .DIVISOR (MAP_WORD_BITS),
    .DVD_W   (PAGE_W),
    .REM_W   (BIT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.page_index),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign cfg.ready    = 1'b1;
  assign req.ready    = state == ST_IDLE;
  assign accept       = req.valid && req.ready;
  assign count_ext    = LW'(page_count);
  assign limit        = BW'((count_ext < LW'(MAX_PAGES)) ? count_ext : LW'(MAX_PAGES));
  assign idx_in_range = LW'(req.page_index) < LW'(limit);
  assign span         = limit - base;
  assign scan_end     = (base + BW'(MAP_WORD_BITS)) >= limit;
  assign div_start    = accept && (req.kind == KIND_FREE || req.kind == KIND_RESERVE)
                        && idx_in_range;

  always_comb begin
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      valid_mask[b] = BW'(b) < span;
    end
    free_bits = ~ram_rdata & valid_mask;
    found_any = |free_bits;
    found_bit = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found_bit = BIT_W'(b);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word;
    ram_wdata = ram_rdata | (map_word_t'(1) << found_bit);
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
      end
      ST_IDLE: begin
        ram_re = accept && req.kind == KIND_ALLOC && limit != '0;
      end
      ST_SCAN: begin
        if (found_any) begin
          ram_we = 1'b1;
        end else if (!scan_end) begin
          ram_re    = 1'b1;
          ram_raddr = WA'(word + 1'b1);
        end
      end
      ST_DIV: begin
        ram_re    = div_done;
        ram_raddr = WA'(div_quot);
      end
      ST_MOD: begin
        ram_we    = 1'b1;
        ram_wdata = (kind_q == KIND_RESERVE) ? ram_rdata | (map_word_t'(1) << div_rem)
                                             : ram_rdata & ~(map_word_t'(1) << div_rem);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      word       <= '0;
      page_count <= PAGE_COUNT_RESET;
      rsp.valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        page_count <= cfg.page_count;
      end
      if (rsp.valid && rsp.ready && state != ST_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (word == LAST_WORD) begin
            word  <= '0;
            state <= ST_IDLE;
          end else begin
            word <= WA'(word + 1'b1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            kind_q <= req.kind;
            idx_q  <= req.page_index;
            if (req.kind == KIND_ALLOC) begin
              if (limit == '0) begin
                res_page <= '0;
                res_ok   <= 1'b0;
                state    <= ST_DONE;
              end else begin
                word  <= '0;
                base  <= '0;
                state <= ST_SCAN;
              end
            end else if (div_start) begin
              state <= ST_DIV;
            end else begin
              res_page <= req.page_index;
              res_ok   <= 1'b0;
              state    <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (found_any) begin
            res_page <= PAGE_W'(base + BW'(found_bit));
            res_ok   <= 1'b1;
            state    <= ST_DONE;
          end else if (scan_end) begin
            res_page <= '0;
            res_ok   <= 1'b0;
            state    <= ST_DONE;
          end else begin
            word <= WA'(word + 1'b1);
            base <= base + BW'(MAP_WORD_BITS);
          end
        end
        ST_DIV: begin
          if (div_done) begin
            word  <= WA'(div_quot);
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          res_page <= idx_q;
          res_ok   <= 1'b1;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.result_page <= res_page;
            rsp.ok          <= res_ok;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BPA_ASSERT_NEXT(a_busy_after_req, accept, !req.ready, "ready held after a request")
  `BPA_ASSERT_NOW(a_div_in_div, div_done, state == ST_DIV, "divider finished outside split")
  `BPA_ASSERT_NOW(a_scan_base, state == ST_SCAN,
    base == BW'(word) * BW'(MAP_WORD_BITS), "scan base out of step with word")
  `BPA_ASSERT_NOW(a_scan_write, state == ST_SCAN && ram_we, found_any,
    "map written in scan with no free page")

endmodule

[tb/bitmap_page_allocator_tb.sv]
`timescale 1ns / 1ps
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int         MAX_FRAMES   = 4096;
  localparam int         STALL_LIMIT  = 3000;
  localparam kind_code_t KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_ITEMS = 850;

  typedef enum logic [1:0] {
    STEP_REQUEST,
    STEP_CONFIG,
    STEP_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t  what;
    kind_code_t  kind;
    page_t       page_index;
    count_t      count;
    int unsigned gap;
  } pending_step_t;

  typedef struct {
    page_t result_page;
    logic  ok;
  } page_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bpa_cfg_if cfg_bus ();
  bpa_req_if req_bus ();
  bpa_rsp_if rsp_bus ();

  bitmap_page_allocator uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  pending_step_t           pending[$];
  page_result_t            expected_rsp[$];
  bit [MAX_FRAMES-1:0]     frame_used_map;
  count_t                  page_count_cfg;
  int                      req_count = 0;
  int                      rsp_count = 0;
  int                      errors = 0;
  int unsigned             gap_left = 0;
  bit                      gap_loaded = 1'b0;
  int unsigned             stall_left = 0;
  int unsigned             hold_left = 0;
  int unsigned             idle_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic add_request(input kind_code_t kind, input page_t idx, input int unsigned gap);
    pending_step_t s;
    s.what = STEP_REQUEST;
    s.kind = kind;
    s.page_index = idx;
    s.count = '0;
    s.gap = gap;
    pending.push_back(s);
  endtask

  task automatic add_drain(input int unsigned gap);
    pending_step_t s;
    s.what = STEP_DRAIN;
    s.kind = KIND_ALLOC;
    s.page_index = '0;
    s.count = '0;
    s.gap = gap;
    pending.push_back(s);
  endtask

  task automatic add_config(input count_t value);
    pending_step_t s;
    add_drain(0);
    s.what = STEP_CONFIG;
    s.kind = KIND_ALLOC;
    s.page_index = '0;
    s.count = value;
    s.gap = 0;
    pending.push_back(s);
  endtask

  task automatic predict_result(input kind_code_t kind, input page_t idx);
    int unsigned  limit;
    page_result_t want;
    bit           found;
    limit = (page_count_cfg > MAX_FRAMES) ? MAX_FRAMES : page_count_cfg;
    want.result_page = idx;
    want.ok = 1'b0;
    found = 1'b0;
    case (kind)
      KIND_ALLOC: begin
        want.result_page = '0;
        for (int f = 0; f < limit && !found; f++) begin
          if (!frame_used_map[f]) begin
            frame_used_map[f] = 1'b1;
            want.result_page = page_t'(f);
            want.ok = 1'b1;
            found = 1'b1;
          end
        end
      end
      KIND_FREE, KIND_RESERVE: begin
        if (idx < limit) begin
          frame_used_map[idx] = (kind == KIND_RESERVE);
          want.ok = 1'b1;
        end
      end
      default: ;
    endcase
    expected_rsp.push_back(want);
  endtask

  always @(posedge clk) begin : request_driver
    logic next_req_valid;
    logic next_cfg_valid;
    if (rst) begin
      req_bus.valid <= 1'b0;
      cfg_bus.valid <= 1'b0;
      frame_used_map = '1;
      page_count_cfg = PAGE_COUNT_RESET;
      req_count = 0;
      gap_loaded = 1'b0;
      gap_left = 0;
    end else begin
      next_req_valid = req_bus.valid;
      next_cfg_valid = cfg_bus.valid;
      if (req_bus.valid && req_bus.ready) begin
        predict_result(req_bus.kind, req_bus.page_index);
        req_count++;
        pending.delete(0);
        next_req_valid = 1'b0;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        page_count_cfg = cfg_bus.page_count;
        pending.delete(0);
        next_cfg_valid = 1'b0;
      end
      if (!next_req_valid && !next_cfg_valid && pending.size() > 0) begin
        if (!gap_loaded) begin
          gap_left = pending[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (pending[0].what)
            STEP_REQUEST: begin
              next_req_valid = 1'b1;
              req_bus.kind <= pending[0].kind;
              req_bus.page_index <= pending[0].page_index;
              gap_loaded = 1'b0;
            end
            STEP_CONFIG: begin
              if (req_count == rsp_count) begin
                next_cfg_valid = 1'b1;
                cfg_bus.page_count <= pending[0].count;
                gap_loaded = 1'b0;
              end
            end
            default: begin
              if (req_count == rsp_count) begin
                pending.delete(0);
                gap_loaded = 1'b0;
              end
            end
          endcase
        end
      end
      req_bus.valid <= next_req_valid;
      cfg_bus.valid <= next_cfg_valid;
    end
  end

  always @(posedge clk) begin : result_monitor
    page_result_t want;
    logic         next_ready;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      rsp_count <= 0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      next_ready = 1'b1;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("unexpected result page %0d ok %0b",
                                    rsp_bus.result_page, rsp_bus.ok));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_bus.result_page !== want.result_page)
            report_mismatch($sformatf("result %0d: result_page %0d, want %0d",
                                      rsp_count, rsp_bus.result_page, want.result_page));
          if (rsp_bus.ok !== want.ok)
            report_mismatch($sformatf("result %0d: ok %0b, want %0b",
                                      rsp_count, rsp_bus.ok, want.ok));
        end
        rsp_count <= rsp_count + 1;
        // hold off long enough to back up the request side
        if (rsp_count == 150 || rsp_count == 520) hold_left = 300;
        stall_left = ((rsp_count / 64) % 3 == 2) ? 0 : $urandom_range(0, 10);
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end
      rsp_bus.ready <= next_ready;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
      $display("** bitmap_page_allocator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned limit;
    int unsigned phase_len;
    int unsigned sel;
    int unsigned n_random;
    bit          calm;
    count_t      cnt;
    kind_code_t  k;
    page_t       idx;

    // every frame starts used
    add_request(KIND_ALLOC, '0, 0);
    add_request(KIND_FREE, 12'hFFF, 2);
    add_request(KIND_FREE, 12'h000, 0);
    add_request(KIND_ALLOC, 12'hFFF, 1);
    add_request(KIND_ALLOC, 12'h000, 0);
    add_request(KIND_ALLOC, 12'h5A5, 3);
    add_request(KIND_FREE, 12'hFFF, 0);
    add_request(KIND_FREE, 12'hFFF, 0);
    add_request(KIND_RESERVE, 12'hFFF, 0);
    add_request(KIND_RESERVE, 12'hFFF, 4);
    add_request(KIND_UNUSED, 12'hABC, 0);
    add_request(KIND_UNUSED, 12'h543, 0);
    add_request(KIND_FREE, 12'd63, 0);
    add_request(KIND_FREE, 12'd64, 0);
    add_request(KIND_ALLOC, '0, 0);
    add_request(KIND_ALLOC, '0, 0);
    add_config(13'd0);
    add_request(KIND_FREE, 12'd0, 0);
    add_request(KIND_RESERVE, 12'd5, 0);
    add_request(KIND_ALLOC, '0, 0);
    add_config(13'h1FFF);
    add_request(KIND_FREE, 12'hFFF, 0);
    add_request(KIND_ALLOC, '0, 0);
    add_config(13'd1);
    add_request(KIND_FREE, 12'd0, 0);
    add_request(KIND_ALLOC, '0, 0);
    add_request(KIND_FREE, 12'd1, 0);

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) cnt = PAGE_COUNT_RESET;
      else if (sel == 1) cnt = 13'h1FFF;
      else if (sel == 2) cnt = 13'd0;
      else if (sel == 3) cnt = 13'd4095;
      else if (sel == 4) cnt = 13'd64;
      else cnt = count_t'($urandom_range(1, 320));
      add_config(cnt);
      limit = (cnt > MAX_FRAMES) ? MAX_FRAMES : cnt;
      calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 80);
      for (int i = 0; i < phase_len; i++) begin
        sel = $urandom_range(0, 99);
        if (i < phase_len / 4) k = KIND_FREE;
        else if (sel < 45) k = KIND_ALLOC;
        else if (sel < 78) k = KIND_FREE;
        else if (sel < 95) k = KIND_RESERVE;
        else k = KIND_UNUSED;
        if (limit > 0 && $urandom_range(0, 9) != 0)
          idx = page_t'($urandom_range(0, limit - 1));
        else
          idx = page_t'($urandom);
        add_request(k, idx, calm ? 0 : $urandom_range(0, 10));
        if ($urandom_range(0, 59) == 0) add_drain($urandom_range(0, 10));
      end
      n_random += phase_len;
    end
    add_config(PAGE_COUNT_RESET);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || req_count != rsp_count) @(negedge clk);
    repeat (80) @(negedge clk);
    if (expected_rsp.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_rsp.size()));
    if (errors == 0) begin
      $display("** bitmap_page_allocator: PASSED **");
    end else begin
      $display("** bitmap_page_allocator: FAILED **");
    end
    $finish;
  end

endmodule
